### rtl/rsbp_pkg.sv
`timescale 1ns / 1ps
package rsbp_pkg;

   localparam int MaxRecordsDefault = 16;
   localparam int BrandBytesDefault = 20;

   typedef struct packed {
      logic [15:0] record_id;
      logic [15:0] processor_code;
      logic [63:0] brand_high;
      logic [63:0] brand_middle;
      logic [31:0] brand_low;
      logic [31:0] price_cents;
   } record_type;

   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   // keeps the characters of a word that fall inside the brand length
   function automatic logic [63:0] brand_mask(input int base, input int nbytes,
                                              input int brand_bytes);
      logic [63:0] m;
      m = '0;
      for (int k = 0; k < 8; k++) begin
         if (k < nbytes && base + k < brand_bytes) begin
            m[8*(nbytes-1-k) +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   // a sorts strictly before b: brand bytes, then price
   function automatic logic key_less(input record_type a, input record_type b);
      return {a.brand_high, a.brand_middle, a.brand_low, a.price_cents} <
             {b.brand_high, b.brand_middle, b.brand_low, b.price_cents};
   endfunction

endpackage

### rtl/rsbp_cell.sv
`timescale 1ns / 1ps
module rsbp_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rsbp_pkg::cell_ctrl_type ctrl,
   input  rsbp_pkg::record_type   new_rec,
   input  rsbp_pkg::record_type   left_rec,
   input  logic                   left_valid,
   input  logic                   left_shift,
   input  rsbp_pkg::record_type   right_rec,
   input  logic                   right_valid,
   output rsbp_pkg::record_type   rec,
   output logic                   valid,
   output logic                   shift
);

   rsbp_pkg::record_type rec_ff, rec_in;
   logic                 valid_ff, valid_in;
   logic                 take;

   // new record goes before this one: this cell moves right
   assign shift = valid_ff && rsbp_pkg::key_less(new_rec, rec_ff);
   // first empty slot also takes the incoming or shifted record
   assign take  = shift || (!valid_ff && left_valid);

   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      if (ctrl.drain) begin
         rec_in   = right_rec;
         valid_in = right_valid;
      end else if (ctrl.insert && take) begin
         rec_in   = left_shift ? left_rec : new_rec;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec   = rec_ff;
   assign valid = valid_ff;

endmodule

### rtl/record_sort_by_brand_then_price.sv
`timescale 1ns / 1ps
// Loading: one request per cycle; each record is placed into the cell chain at once, but
// a request that meets a full chain is dropped and sets the overflow flag. A request
// marked last starts emission the next cycle: one sorted record per cycle, busy high
// throughout. Results cannot be stalled.
// Synchronous reset empties the chain, clears the overflow flag, returns to loading.
module record_sort_by_brand_then_price #(
   parameter int MAX_RECORDS = rsbp_pkg::MaxRecordsDefault,
   parameter int BRAND_BYTES = rsbp_pkg::BrandBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_record_id,
   input  logic [15:0] req_processor_code,
   input  logic [63:0] req_brand_bytes_0_7,
   input  logic [63:0] req_brand_bytes_8_15,
   input  logic [31:0] req_brand_bytes_16_19,
   input  logic [31:0] req_price_cents,
   input  logic        req_last_record,
   output logic        rsp_strobe,
   output logic [15:0] rsp_out_record_id,
   output logic [15:0] rsp_out_processor_code,
   output logic [63:0] rsp_out_brand_bytes_0_7,
   output logic [63:0] rsp_out_brand_bytes_8_15,
   output logic [31:0] rsp_out_brand_bytes_16_19,
   output logic [31:0] rsp_out_price_cents,
   output logic        rsp_out_last,
   output logic        rsp_overflow_seen
);

   localparam logic [63:0] MaskHigh   = rsbp_pkg::brand_mask(0, 8, BRAND_BYTES);
   localparam logic [63:0] MaskMiddle = rsbp_pkg::brand_mask(8, 8, BRAND_BYTES);
   localparam logic [63:0] MaskLow    = rsbp_pkg::brand_mask(16, 4, BRAND_BYTES);

   rsbp_pkg::state_type     state_ff, state_in;
   logic                    ovf_ff, ovf_in;
   logic                    accept, full;
   rsbp_pkg::cell_ctrl_type ctrl;
   rsbp_pkg::record_type    new_rec;
   rsbp_pkg::record_type    cell_rec   [MAX_RECORDS];
   logic [MAX_RECORDS-1:0]  cell_valid;
   logic [MAX_RECORDS-1:0]  cell_shift;

   assign busy   = (state_ff == rsbp_pkg::ST_DRAIN);
   assign accept = start && !busy;
   assign full   = cell_valid[MAX_RECORDS-1];

   assign new_rec.record_id      = req_record_id;
   assign new_rec.processor_code = req_processor_code;
   assign new_rec.brand_high     = req_brand_bytes_0_7 & MaskHigh;
   assign new_rec.brand_middle   = req_brand_bytes_8_15 & MaskMiddle;
   assign new_rec.brand_low      = req_brand_bytes_16_19 & MaskLow[31:0];
   assign new_rec.price_cents    = req_price_cents;

   assign ctrl.insert = accept && !full;
   assign ctrl.drain  = busy;

   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      rsbp_pkg::record_type left_rec, right_rec;
      logic                 left_valid, left_shift, right_valid;
      if (i == 0) begin : g_head
         assign left_rec   = new_rec;
         assign left_valid = 1'b1;
         assign left_shift = 1'b0;
      end else begin : g_body
         assign left_rec   = cell_rec[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_shift = cell_shift[i-1];
      end
      if (i == MAX_RECORDS - 1) begin : g_tail
         assign right_rec   = cell_rec[i];
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_rec   = cell_rec[i+1];
         assign right_valid = cell_valid[i+1];
      end
      rsbp_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_rec     (new_rec),
         .left_rec    (left_rec),
         .left_valid  (left_valid),
         .left_shift  (left_shift),
         .right_rec   (right_rec),
         .right_valid (right_valid),
         .rec         (cell_rec[i]),
         .valid       (cell_valid[i]),
         .shift       (cell_shift[i])
      );
   end

   assign rsp_strobe                = busy;
   assign rsp_out_record_id         = cell_rec[0].record_id;
   assign rsp_out_processor_code    = cell_rec[0].processor_code;
   assign rsp_out_brand_bytes_0_7   = cell_rec[0].brand_high;
   assign rsp_out_brand_bytes_8_15  = cell_rec[0].brand_middle;
   assign rsp_out_brand_bytes_16_19 = cell_rec[0].brand_low;
   assign rsp_out_price_cents       = cell_rec[0].price_cents;
   assign rsp_out_last              = !cell_valid[1];
   assign rsp_overflow_seen         = ovf_ff;

   always_comb begin
      state_in = state_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         rsbp_pkg::ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end
               if (req_last_record) begin
                  state_in = rsbp_pkg::ST_DRAIN;
               end
            end
         end
         rsbp_pkg::ST_DRAIN: begin
            if (rsp_out_last) begin
               state_in = rsbp_pkg::ST_LOAD;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = rsbp_pkg::ST_LOAD;
            ovf_in   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsbp_pkg::ST_LOAD;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
      end
   end

   a_drain_has_data: assert property (@(posedge clock) disable iff (reset)
      busy |-> cell_valid[0])
      else $error("emitting from an empty chain");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_last |=> !rsp_strobe)
      else $error("emission continued past the last record");

   a_last_starts_run: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_record |=> rsp_strobe)
      else $error("last request did not start emission");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_valid[1] |-> !rsbp_pkg::key_less(cell_rec[1], cell_rec[0]))
      else $error("chain head out of order");

endmodule
